// ===== src/heap_sort_engine_assert.svh =====
// Assertion macros shared by the heap sort engine modules.
// Both expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef HEAP_SORT_ENGINE_ASSERT_SVH
`define HEAP_SORT_ENGINE_ASSERT_SVH

// Same-cycle implication
`define HSE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define HSE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/hse_pkg.sv =====
package hse_pkg;

  localparam int DATA_W = 32;
  // Wide enough for an element count up to the largest supported capacity
  localparam int CNT_W  = 7;

  typedef logic signed [DATA_W-1:0] hse_data_t;

  // Control from the collector to the sorter
  typedef struct packed {
    logic             wr_en;
    logic [CNT_W-1:0] wr_addr;
    hse_data_t        wr_data;
    logic             go;
    logic [CNT_W-1:0] size;
    logic             min_mode;
  } hse_ctrl_t;

  // Sorted element offered by the sorter
  typedef struct packed {
    logic      valid;
    hse_data_t value;
    logic      last;
  } hse_emit_t;

endpackage

// ===== src/hse_if.sv =====
interface hse_in_if;
  logic                valid;
  logic                ready;
  hse_pkg::hse_data_t  value;
  logic                last_in;
  modport source(output valid, value, last_in, input ready);
  modport sink(input valid, value, last_in, output ready);
endinterface

interface hse_out_if;
  logic                valid;
  logic                ready;
  hse_pkg::hse_data_t  sorted_value;
  logic                last_out;
  logic                overflow;
  modport source(output valid, sorted_value, last_out, overflow, input ready);
  modport sink(input valid, sorted_value, last_out, overflow, output ready);
endinterface

interface hse_cfg_if;
  logic valid;
  logic ready;
  logic order_mode;
  modport source(output valid, order_mode, input ready);
  modport sink(input valid, order_mode, output ready);
endinterface

// ===== src/hse_sorter.sv =====
`include "heap_sort_engine_assert.svh"

module hse_sorter #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  hse_pkg::hse_ctrl_t ctrl,
  output hse_pkg::hse_emit_t emit,
  input  logic               emit_ready,
  output logic               idle
);
  import hse_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = CW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_BLD_NEXT, S_LD_CUR, S_EXT_NEXT, S_EXT_SWAP,
    S_SIFT_RD, S_SIFT_CL, S_SIFT_CR, S_EMIT_RD, S_EMIT_OUT
  } state_t;

  state_t          state_r;
  logic            phase_ext_r;
  logic            min_mode_r;
  logic [CW-1:0]   n_r;
  logic [CW-1:0]   bi_r;
  logic [CW-1:0]   es_r;
  logic [CW-1:0]   hs_r;
  logic [AW-1:0]   ii_r;
  logic [AW-1:0]   k_r;
  hse_data_t       cur_r;
  hse_data_t       cand_r;
  logic            cand_child_r;
  logic            l_ok_r;
  logic            r_ok_r;
  hse_data_t       rd0_r;
  hse_data_t       rd1_r;

  hse_data_t       mem [CAPACITY];

  logic [LW-1:0]   l_idx;
  logic [LW-1:0]   r_idx;
  hse_data_t       cmp_a;
  hse_data_t       cmp_b;
  logic            cmp_above;
  logic            take_r;
  logic            best_child;
  hse_data_t       best_val;
  logic [AW-1:0]   best_idx;
  logic            emit_last;
  logic            rd_en;
  logic [AW-1:0]   ra0;
  logic [AW-1:0]   ra1;
  logic            we;
  logic [AW-1:0]   wa;
  hse_data_t       wd;

  // Child positions of the current hole
  assign l_idx = LW'({ii_r, 1'b0}) + LW'(1);
  assign r_idx = l_idx + LW'(1);

  // Shared compare unit: left child against the sifted value, then right against the winner
  assign cmp_a     = (state_r == S_SIFT_CL) ? rd0_r : rd1_r;
  assign cmp_b     = (state_r == S_SIFT_CL) ? cur_r : cand_r;
  assign cmp_above = min_mode_r ? (cmp_a < cmp_b) : (cmp_a > cmp_b);

  assign take_r     = r_ok_r && cmp_above;
  assign best_child = take_r || cand_child_r;
  assign best_val   = take_r ? rd1_r : cand_r;
  assign best_idx   = take_r ? r_idx[AW-1:0] : l_idx[AW-1:0];

  assign emit_last  = (CW'(k_r) == (n_r - CW'(1)));

  // Read port addresses
  always_comb begin
    rd_en = 1'b0;
    ra0   = '0;
    ra1   = '0;
    unique case (state_r)
      S_BLD_NEXT: begin
        rd_en = 1'b1;
        ra0   = AW'(bi_r - CW'(1));
      end
      S_EXT_NEXT: begin
        rd_en = 1'b1;
        ra1   = AW'(es_r - CW'(1));
      end
      S_SIFT_RD: begin
        rd_en = 1'b1;
        ra0   = l_idx[AW-1:0];
        ra1   = r_idx[AW-1:0];
      end
      S_EMIT_RD: begin
        rd_en = 1'b1;
        ra0   = k_r;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Write port: collected values while idle, heap moves while sorting
  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = ctrl.wr_data;
    unique case (state_r)
      S_IDLE: begin
        we = ctrl.wr_en;
        wa = ctrl.wr_addr[AW-1:0];
        wd = ctrl.wr_data;
      end
      S_EXT_SWAP: begin
        we = 1'b1;
        wa = AW'(es_r - CW'(1));
        wd = rd0_r;
      end
      S_SIFT_CR: begin
        we = 1'b1;
        wa = ii_r;
        wd = best_child ? best_val : cur_r;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Element store with registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd0_r <= mem[ra0];
      rd1_r <= mem[ra1];
    end
  end

  // Sequencer: build the heap, extract the root repeatedly, then stream out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (ctrl.go) begin
            n_r        <= ctrl.size[CW-1:0];
            bi_r       <= ctrl.size[CW-1:0] >> 1;
            es_r       <= ctrl.size[CW-1:0];
            min_mode_r <= ctrl.min_mode;
            state_r    <= S_BLD_NEXT;
          end
        end
        S_BLD_NEXT: begin
          if (bi_r == '0) begin
            phase_ext_r <= 1'b1;
            state_r     <= S_EXT_NEXT;
          end else begin
            bi_r        <= bi_r - CW'(1);
            ii_r        <= AW'(bi_r - CW'(1));
            hs_r        <= n_r;
            phase_ext_r <= 1'b0;
            state_r     <= S_LD_CUR;
          end
        end
        S_LD_CUR: begin
          cur_r   <= rd0_r;
          state_r <= S_SIFT_RD;
        end
        S_EXT_NEXT: begin
          if (es_r <= CW'(1)) begin
            k_r     <= '0;
            state_r <= S_EMIT_RD;
          end else begin
            state_r <= S_EXT_SWAP;
          end
        end
        S_EXT_SWAP: begin
          // old root went to the tail; the tail value sifts down from the root
          cur_r   <= rd1_r;
          ii_r    <= '0;
          hs_r    <= es_r - CW'(1);
          es_r    <= es_r - CW'(1);
          state_r <= S_SIFT_RD;
        end
        S_SIFT_RD: begin
          l_ok_r  <= (l_idx < LW'(hs_r));
          r_ok_r  <= (r_idx < LW'(hs_r));
          state_r <= S_SIFT_CL;
        end
        S_SIFT_CL: begin
          if (l_ok_r && cmp_above) begin
            cand_r       <= rd0_r;
            cand_child_r <= 1'b1;
          end else begin
            cand_r       <= cur_r;
            cand_child_r <= 1'b0;
          end
          state_r <= S_SIFT_CR;
        end
        S_SIFT_CR: begin
          if (best_child) begin
            ii_r    <= best_idx;
            state_r <= S_SIFT_RD;
          end else begin
            state_r <= phase_ext_r ? S_EXT_NEXT : S_BLD_NEXT;
          end
        end
        S_EMIT_RD: begin
          state_r <= S_EMIT_OUT;
        end
        S_EMIT_OUT: begin
          if (emit_ready) begin
            if (emit_last) begin
              state_r <= S_IDLE;
            end else begin
              k_r     <= k_r + AW'(1);
              state_r <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign emit.valid = (state_r == S_EMIT_OUT);
  assign emit.value = rd0_r;
  assign emit.last  = emit_last;
  assign idle       = (state_r == S_IDLE);

  `HSE_ASSERT_IMP(a_sift_in_heap, state_r == S_SIFT_CR, CW'(ii_r) < hs_r, "hole outside heap")
  `HSE_ASSERT_IMP(a_emit_in_set, state_r == S_EMIT_OUT, CW'(k_r) < n_r, "emit beyond set")
  `HSE_ASSERT_NXT(a_swap_to_root, state_r == S_EXT_SWAP, state_r == S_SIFT_RD && ii_r == '0,
                  "extraction must sift from the root")

endmodule

// ===== src/heap_sort_engine.sv =====
// Channel    Dir  Payload                               Transaction when
// in_chan    in   value, last_in                        valid && ready
// out_chan   out  sorted_value, last_out, overflow      valid && ready
// cfg_chan   in   order_mode                            valid (ready always high)
//
// A value without last_in is stored. last_in starts a heap sort of the stored set:
// each heap level of each sift reads both children and compares them in turn
// through the shared comparator, writing through the single-write element store;
// the sorted elements are then emitted in order. in_chan stays not ready from the
// last_in transaction until the final result is taken. out_chan stalls hold the
// output register and the sorter. Reset (rst_n low, synchronous) clears the count,
// overflow flag and order_mode; the element store is not cleared.
`include "heap_sort_engine_assert.svh"

module heap_sort_engine #(
  parameter int CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  hse_in_if.sink     in_chan,
  hse_out_if.source  out_chan,
  hse_cfg_if.sink    cfg_chan
);
  import hse_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic          order_mode_r;
  logic [CW-1:0] count_r;
  logic          flag_r;
  logic          busy_r;
  logic          out_valid_r;
  hse_data_t     out_value_r;
  logic          out_last_r;
  logic          out_ovf_r;

  logic          in_acc;
  logic          has_room;
  logic [CW-1:0] count_inc;
  logic          emit_ready;
  logic          load;
  logic          sorter_idle;
  hse_ctrl_t     ctrl;
  hse_emit_t     emit;

  assign in_acc    = in_chan.valid && in_chan.ready;
  assign has_room  = (count_r < CW'(CAPACITY));
  assign count_inc = count_r + CW'(1);

  assign in_chan.ready  = !busy_r;
  assign cfg_chan.ready = 1'b1;

  // Store request and sort start
  assign ctrl.wr_en    = in_acc && has_room;
  assign ctrl.wr_addr  = CNT_W'(count_r);
  assign ctrl.wr_data  = in_chan.value;
  assign ctrl.go       = in_acc && in_chan.last_in;
  assign ctrl.size     = has_room ? CNT_W'(count_inc) : CNT_W'(count_r);
  assign ctrl.min_mode = order_mode_r;

  hse_sorter #(
    .CAPACITY(CAPACITY)
  ) u_sorter (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .emit       (emit),
    .emit_ready (emit_ready),
    .idle       (sorter_idle)
  );

  // Output register takes a new element whenever it is empty or being drained
  assign emit_ready = !out_valid_r || out_chan.ready;
  assign load       = emit.valid && emit_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_mode_r <= 1'b0;
      count_r      <= '0;
      flag_r       <= 1'b0;
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // config write
      if (cfg_chan.valid) begin
        order_mode_r <= cfg_chan.order_mode;
      end

      // collect, or drop and flag when full
      if (in_acc) begin
        if (!has_room) begin
          flag_r <= 1'b1;
        end
        if (in_chan.last_in) begin
          count_r <= '0;
          busy_r  <= 1'b1;
        end else if (has_room) begin
          count_r <= count_inc;
        end
      end

      // advance output register
      if (load) begin
        out_valid_r <= 1'b1;
        out_value_r <= emit.value;
        out_last_r  <= emit.last;
        out_ovf_r   <= flag_r;
        if (emit.last) begin
          flag_r <= 1'b0;
        end
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      // release input once the final result is taken
      if (out_valid_r && out_chan.ready && out_last_r) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.sorted_value = out_value_r;
  assign out_chan.last_out     = out_last_r;
  assign out_chan.overflow     = out_ovf_r;

  `HSE_ASSERT_IMP(a_go_when_idle, ctrl.go, sorter_idle, "sort started while sorter busy")
  `HSE_ASSERT_IMP(a_out_while_busy, out_valid_r, busy_r, "result outside a sort")
  `HSE_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CW'(CAPACITY), "count above capacity")
  `HSE_ASSERT_NXT(a_last_clears_count, in_acc && in_chan.last_in, count_r == '0 && busy_r,
                  "last transaction must clear count and block input")

endmodule

// ===== tb/sv/heap_sort_engine_tb.sv =====
`timescale 1ns / 100ps

module heap_sort_engine_tb;
  import hse_pkg::*;

  localparam int CAPACITY    = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 40;
  localparam int LONG_HOLD   = 400;
  localparam int RAND_ITEMS  = 160;
  localparam int CALM_AFTER  = 140;
  localparam int MAX_REPORTS = 10;

  localparam hse_data_t MAX_VAL = 32'sh7FFF_FFFF;
  localparam hse_data_t MIN_VAL = 32'sh8000_0000;

  localparam logic ORDER_ASCENDING  = 1'b0;
  localparam logic ORDER_DESCENDING = 1'b1;

  typedef struct {
    hse_data_t value;
    logic      is_final;
    logic      ovf;
  } sorted_item_t;

  // Collects the current set, predicts its sorted output and checks results
  class sorted_output_check;
    hse_data_t    held[$];
    logic         dropped;
    logic         descending;
    sorted_item_t sorted_due[$];
    int unsigned  mismatches;

    function new();
      dropped    = 1'b0;
      descending = ORDER_ASCENDING;
      mismatches = 0;
    endfunction

    function void set_order(logic mode);
      descending = mode;
    endfunction

    function int pending();
      return sorted_due.size();
    endfunction

    // Insertion sort of the held set in the selected direction
    function void sort_set();
      hse_data_t    arr[$];
      hse_data_t    key;
      sorted_item_t item;
      int           j;
      arr = held;
      for (int i = 1; i < arr.size(); i++) begin
        key = arr[i];
        j = i - 1;
        while (j >= 0 && (descending ? (arr[j] < key) : (arr[j] > key))) begin
          arr[j+1] = arr[j];
          j--;
        end
        arr[j+1] = key;
      end
      for (int k = 0; k < arr.size(); k++) begin
        item.value    = arr[k];
        item.is_final = (k == arr.size() - 1);
        item.ovf      = dropped;
        sorted_due.push_back(item);
      end
    endfunction

    // Store or drop an accepted value; sort and clear on the final one
    function void note_value(hse_data_t v, logic is_final);
      if (held.size() < CAPACITY) begin
        held.push_back(v);
      end else begin
        dropped = 1'b1;
      end
      if (is_final) begin
        sort_set();
        held.delete();
        dropped = 1'b0;
      end
    endfunction

    function void check_result(hse_data_t got_value, logic got_final, logic got_ovf);
      sorted_item_t want;
      if (sorted_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected result: value %0d last %0b overflow %0b",
                   got_value, got_final, got_ovf);
        end
        return;
      end
      want = sorted_due.pop_front();
      if (got_value !== want.value || got_final !== want.is_final ||
          got_ovf !== want.ovf) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("result mismatch: expected value %0d last %0b overflow %0b",
                   want.value, want.is_final, want.ovf);
          $display("  got value %0d last %0b overflow %0b",
                   got_value, got_final, got_ovf);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  hse_in_if  in_if();
  hse_out_if out_if();
  hse_cfg_if cfg_if();

  heap_sort_engine #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  sorted_output_check board;
  bit                 calm;
  int unsigned        cycle_count;
  int unsigned        results_taken;
  int unsigned        rand_items;

  // Generate a 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // End the run at the cycle limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Offer one value, with an occasional idle burst in front of it
  task automatic push_value(input hse_data_t v, input logic is_final);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.value   <= v;
    in_if.last_in <= is_final;
    do @(posedge clk); while (!in_if.ready);
    board.note_value(v, is_final);
  endtask

  // Drop valid and wait until every expected result has been taken
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_order(input logic mode);
    cfg_if.valid      <= 1'b1;
    cfg_if.order_mode <= mode;
    do @(posedge clk); while (!cfg_if.ready);
    board.set_order(mode);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic hse_data_t pick_value();
    case ($urandom_range(0, 7))
      0:       return MAX_VAL;
      1:       return MIN_VAL;
      2, 3:    return hse_data_t'($signed($urandom_range(0, 8)) - 4);
      default: return hse_data_t'($urandom);
    endcase
  endfunction

  task automatic push_random_set(input int size);
    for (int k = 0; k < size; k++) begin
      push_value(pick_value(), k == size - 1);
      rand_items++;
      if (rand_items >= CALM_AFTER) calm = 1'b1;
    end
  endtask

  // Take results with random stalls and one long hold-off
  initial begin
    bit long_hold_done;
    long_hold_done = 1'b0;
    results_taken  = 0;
    out_if.ready   <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!long_hold_done && results_taken >= 10) begin
        long_hold_done = 1'b1;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      board.check_result(out_if.sorted_value, out_if.last_out, out_if.overflow);
      results_taken++;
    end
  end

  // Main stimulus
  initial begin
    int forced_sizes[2] = '{65, 67};
    int size;
    // Drive every input to a known value before the first edge
    board             = new();
    calm              = 1'b0;
    rst_n             = 1'b0;
    in_if.valid       <= 1'b0;
    in_if.value       <= '0;
    in_if.last_in     <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.order_mode <= ORDER_ASCENDING;
    rand_items = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, single-element set, duplicates, both orders
    write_order(ORDER_ASCENDING);
    push_value(MAX_VAL, 1'b0);
    push_value(MIN_VAL, 1'b0);
    push_value(32'sd0, 1'b0);
    push_value(-32'sd1, 1'b0);
    push_value(32'sd1, 1'b1);
    push_value(32'sd42, 1'b1);
    drain_results();

    write_order(ORDER_DESCENDING);
    push_value(32'sd5, 1'b0);
    push_value(-32'sd3, 1'b0);
    push_value(32'sd5, 1'b0);
    push_value(32'sd5, 1'b0);
    push_value(-32'sd3, 1'b0);
    push_value(MIN_VAL, 1'b0);
    push_value(MAX_VAL, 1'b0);
    push_value(32'sd5, 1'b1);
    push_value(-32'sd1, 1'b0);
    push_value(MAX_VAL, 1'b1);
    drain_results();

    write_order(ORDER_ASCENDING);
    push_value(32'sd3, 1'b0);
    push_value(32'sd3, 1'b0);
    push_value(32'sd3, 1'b1);

    // Random: two overfull sets first, then mostly small sets
    foreach (forced_sizes[i]) begin
      drain_results();
      write_order(logic'($urandom_range(0, 1)));
      push_random_set(forced_sizes[i]);
    end
    while (rand_items < RAND_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        drain_results();
        write_order(logic'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 11) == 0) begin
        size = $urandom_range(60, 68);
      end else begin
        size = $urandom_range(1, 10);
      end
      // Trim the final set to the item budget
      if (size > int'(RAND_ITEMS - rand_items)) begin
        size = int'(RAND_ITEMS - rand_items);
      end
      push_random_set(size);
    end

    // Hold until everything is back, then give trailing results a chance
    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/hse_pkg.sv
src/hse_if.sv
src/hse_sorter.sv
src/heap_sort_engine.sv
tb/sv/heap_sort_engine_tb.sv
